### hw/rtl/dtbs_pkg.sv
`timescale 1ns / 1ps

package dtbs_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
   localparam int VOLT_W      = 16;
   localparam int IDX_W       = 6;

   // CSR port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Register index of table_length
   localparam logic REG_TABLE_LENGTH = 1'b0;

   typedef struct packed {
      logic                     opcode;
      logic [IDX_W-1:0]         entry_index;
      logic signed [VOLT_W-1:0] entry_volt;
      logic signed [VOLT_W-1:0] search_volt;
      logic                     want_lower;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0] found_index;
      logic             table_empty;
   } rsp_word_type;

   typedef struct packed {
      logic write;   // store entry from the incoming word
      logic load;    // capture search operands, init bounds
      logic step;    // apply one probe compare
      logic emit;    // load result register
   } dp_cmd_type;

   typedef struct packed {
      logic searching;   // lo <= hi still
      logic hit;         // probed entry equals target
      logic out_free;    // result register can take a word
   } dp_status_type;

endpackage

### hw/rtl/dtbs_ram.sv
`timescale 1ns / 1ps

module dtbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dtbs_datapath.sv
`timescale 1ns / 1ps

module dtbs_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  dtbs_pkg::dp_cmd_type              cmd,
   output dtbs_pkg::dp_status_type           status,
   input  dtbs_pkg::req_word_type            req_word,
   input  logic [dtbs_pkg::LEN_W-1:0]        table_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dtbs_pkg::rsp_word_type            rsp_word
);

   localparam int LW = dtbs_pkg::LEN_W;
   localparam int AW = dtbs_pkg::ADDR_W;
   localparam int IW = dtbs_pkg::IDX_W;
   localparam logic [LW-1:0] DEPTH_L = LW'(dtbs_pkg::TABLE_DEPTH);

   logic signed [dtbs_pkg::VOLT_W-1:0] target_ff, target_in;
   logic                               lower_ff, lower_in;
   logic [LW-1:0]                      len_ff, len_in;
   logic [LW-1:0]                      lo_ff, lo_in;
   // hi kept as hi+1 so it stays non-negative
   logic [LW-1:0]                      hix_ff, hix_in;
   logic                               hit_ff, hit_in;
   logic [IW-1:0]                      hit_idx_ff, hit_idx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   dtbs_pkg::rsp_word_type             rsp_word_ff, rsp_word_in;

   logic [LW-1:0]                      len_sat;
   logic [LW-1:0]                      span;
   logic [LW-1:0]                      mid;
   logic [dtbs_pkg::VOLT_W-1:0]        rd_data;
   logic                               hit_now;
   logic                               less_now;
   dtbs_pkg::rsp_word_type             result;

   dtbs_ram #(
      .WIDTH (dtbs_pkg::VOLT_W),
      .DEPTH (dtbs_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (req_word.entry_index[AW-1:0]),
      .wr_data (req_word.entry_volt),
      .rd_addr (mid[AW-1:0]),
      .rd_data (rd_data)
   );

   assign len_sat  = (table_length > DEPTH_L) ? DEPTH_L : table_length;
   assign span     = hix_ff - lo_ff - LW'(1);
   assign mid      = lo_ff + (span >> 1);
   assign hit_now  = ($signed(rd_data) == target_ff);
   assign less_now = ($signed(rd_data) < target_ff);

   assign status.searching = (lo_ff < hix_ff);
   assign status.hit       = hit_now;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Final index: exact hit, else bracket clamped to the table
   always_comb begin
      result.table_empty = (len_ff == '0);
      if (len_ff == '0) begin
         result.found_index = '0;
      end else if (hit_ff) begin
         result.found_index = hit_idx_ff;
      end else if (lo_ff == '0) begin
         result.found_index = '0;
      end else if (lo_ff == len_ff) begin
         result.found_index = IW'(len_ff - LW'(1));
      end else if (lower_ff) begin
         result.found_index = IW'(lo_ff - LW'(1));
      end else begin
         result.found_index = IW'(lo_ff);
      end
   end

   always_comb begin
      target_in    = target_ff;
      lower_in     = lower_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hix_in       = hix_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         target_in = req_word.search_volt;
         lower_in  = req_word.want_lower;
         len_in    = len_sat;
         lo_in     = '0;
         hix_in    = len_sat;
         hit_in    = 1'b0;
      end
      if (cmd.step) begin
         if (hit_now) begin
            hit_in     = 1'b1;
            hit_idx_in = IW'(mid);
         end else if (less_now) begin
            hix_in = mid;
         end else begin
            lo_in = mid + LW'(1);
         end
      end
      if (cmd.emit) begin
         rsp_word_in  = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
      end
      target_ff   <= target_in;
      lower_ff    <= lower_in;
      len_ff      <= len_in;
      lo_ff       <= lo_in;
      hix_ff      <= hix_in;
      hit_idx_ff  <= hit_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### hw/rtl/dtbs_ctrl.sv
`timescale 1ns / 1ps

module dtbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_opcode,
   output logic                    req_stall,
   input  dtbs_pkg::dp_status_type status,
   output dtbs_pkg::dp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == dtbs_pkg::OP_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = ST_ISSUE;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            // read of the mid entry is in flight when searching
            state_in = status.searching ? ST_CMP : ST_EMIT;
         end
         ST_CMP: begin
            cmd.step = 1'b1;
            state_in = status.hit ? ST_EMIT : ST_ISSUE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/descending_table_bracket_search_unit.sv
`timescale 1ns / 1ps

// Bracket search over a table of signed 16-bit voltages held in descending
// order. A write word (opcode 0) stores entry_volt at entry_index and gives
// no result. A search word (opcode 1) binary-searches the first
// table_length entries (CSR at byte 0, 7 bits wide, values above 64 act as
// 64) for search_volt and returns one result word: the matching index on an
// exact hit, else the insertion point, or the entry before it when
// want_lower is set, clamped to 0 .. table_length-1. With table_length zero
// the result is index 0 with table_empty set. A search holds the input while
// it runs its table probes, at most 7 for a 64-entry table; each probe is an
// address state (ISSUE) and a compare state (CMP) around the table RAM's
// registered read port. The result sits in an output register, so a new word
// is taken while an earlier result still waits on rsp_stall; a later search
// that finishes first holds the input in its EMIT state until that result
// leaves. Only entries that have been written may fall on the probe path;
// table_length is to be written by the user only while the block is idle;
// the block itself does not enforce this.

module descending_table_bracket_search_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dtbs_pkg::req_word_type                req_word,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dtbs_pkg::rsp_word_type                rsp_word,
   // CSR port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [dtbs_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [dtbs_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [dtbs_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int LW = dtbs_pkg::LEN_W;

   logic [LW-1:0]           table_length_ff, table_length_in;
   logic                    csr_sel_len;
   dtbs_pkg::dp_cmd_type    cmd;
   dtbs_pkg::dp_status_type status;

   // ---- CSR: single register, word aligned, low address bits ignored ----
   assign pready      = 1'b1;
   assign csr_sel_len = (paddr[dtbs_pkg::CSR_ADDR_W-1] == dtbs_pkg::REG_TABLE_LENGTH);

   always_comb begin
      table_length_in = table_length_ff;
      if (psel && penable && pwrite && csr_sel_len) begin
         table_length_in = pwdata[LW-1:0];
      end
   end

   assign prdata = csr_sel_len ? dtbs_pkg::CSR_DATA_W'(table_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= '0;
      end else begin
         table_length_ff <= table_length_in;
      end
   end

   // ---- sequencer: accept, probe loop, result hand-off ----
   dtbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_word.opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // ---- table RAM, search bounds, result register ----
   dtbs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_word     (req_word),
      .table_length (table_length_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

endmodule
